// File: rtl/bsbm_pkg.sv
// bsbm_pkg: item types, register codes and widths shared by the
// boundary marker modules; no dependencies
package bsbm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int IMAGE_WIDTH_W  = 8;
    localparam int IMAGE_HEIGHT_W = 11;
    localparam int WIDTH_RESET  = 128;
    localparam int HEIGHT_RESET = 1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_UNUSED_2     = 2'd2,
        REG_UNUSED_3     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic action;
        logic pixel_filled;
    } in_item_t;

    typedef struct packed {
        logic is_boundary;
        logic row_end;
        logic image_end;
    } out_item_t;

    // control of one row store for the current item
    typedef struct packed {
        logic step;   // move the read window on
        logic wrap;   // window back to column zero
        logic wr_en;  // store the current column
    } lb_ctrl_t;

endpackage

// File: rtl/bsbm_line_buf.sv
// bsbm_line_buf: one row store with a two-entry read window (column c, c+1)
// depends on bsbm_pkg
module bsbm_line_buf #(
    parameter int DEPTH = 128
) (
    input  logic                       aclk,
    input  bsbm_pkg::lb_ctrl_t         ctrl,
    input  logic [$clog2(DEPTH)-1:0]   col,
    input  logic                       wr_data,
    output logic                       cur_bit,
    output logic                       nxt_bit
);
    import bsbm_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic             mem [0:(1<<AW)-1];
    logic             cur_reg;
    logic             nxt_reg;
    logic [AW-1:0]    ahead_addr;

    assign ahead_addr = col + AW'(2);
    assign cur_bit    = cur_reg;
    assign nxt_bit    = nxt_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[col] <= wr_data;
        end
        if (ctrl.step) begin
            if (ctrl.wrap) begin
                // the row that is being written now may be the one read back
                cur_reg <= (ctrl.wr_en && col == AW'(0)) ? wr_data : mem[AW'(0)];
                nxt_reg <= (ctrl.wr_en && col == AW'(1)) ? wr_data : mem[AW'(1)];
            end else begin
                cur_reg <= nxt_reg;
                nxt_reg <= mem[ahead_addr];
            end
        end
    end

endmodule

// File: rtl/bsbm_out_queue.sv
// bsbm_out_queue: two-entry result buffer between the marker and m_ side
// depends on bsbm_pkg
module bsbm_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bsbm_pkg::out_item_t push_data,
    output logic                has_room,
    output logic                m_valid,
    input  logic                m_ready,
    output bsbm_pkg::out_item_t m_data
);
    import bsbm_pkg::*;

    out_item_t  ent_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = count_reg != 2'd0;
    assign m_data   = ent_reg[rd_ptr_reg];
    assign has_room = count_reg != 2'd2;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/binary_shape_boundary_marker_core.sv
// binary_shape_boundary_marker_core: top level of the 4-neighbour boundary marker
// depends on bsbm_pkg, bsbm_line_buf, bsbm_out_queue
//
// Pixels enter on the s_ channel in raster order, one item each. While row r+1
// loads, row r leaves on the m_ channel, one result per pixel: is_boundary marks
// a filled pixel with an empty left, right, upper or lower neighbour, row_end
// flags the last column. Row 0 gives no results. After the last row, flush items
// (action = 1) emit that row; image_end marks its last pixel. Flushes while
// loading and pixels while flushing are dropped without a result.
// cfg_index 0 sets image_width, 1 sets image_height; a write to either restarts the image.
// Write the registers only while no item is in flight.
// Timing: one item per clock, set by the combinational neighbour logic between the
// row-store read window and the result buffer; a result is visible on m_ in the
// cycle after its item is taken. A two-entry buffer holds results, so s_ready
// stays high while one result waits and drops only when both entries are full.
// Reset: restarts at row 0, column 0 with width 128 and height 1024 (clamped to
// MAX_WIDTH and MAX_HEIGHT); row-store contents are not cleared.
module binary_shape_boundary_marker_core #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  bsbm_pkg::in_item_t                     s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output bsbm_pkg::out_item_t                    m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bsbm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [bsbm_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import bsbm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int RST_H = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          flushing_reg;
    logic          left_reg;
    logic [CW-1:0] last_col_idx_reg;
    logic [RW-1:0] last_row_idx_reg;

    logic [CW-1:0] last_col_idx_next;
    logic [RW-1:0] last_row_idx_next;
    logic [IMAGE_WIDTH_W-1:0]  w_val;
    logic [IMAGE_HEIGHT_W-1:0] h_val;

    logic      accept;
    logic      cfg_write;
    logic      is_known_reg;
    logic      load_step;
    logic      flush_step;
    logic      last_col;
    logic      emit;
    out_item_t result;
    lb_ctrl_t  up_ctrl;
    lb_ctrl_t  mid_ctrl;
    logic      up_cur;
    logic      up_nxt;
    logic      mid_cur;
    logic      mid_nxt;
    logic      up_n;
    logic      left_n;
    logic      right_n;
    logic      queue_room;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign is_known_reg = (cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT);

    assign s_ready    = queue_room;
    assign accept     = s_valid && s_ready;
    assign load_step  = accept && !flushing_reg && !s_data.action;
    assign flush_step = accept && flushing_reg && s_data.action;
    assign last_col   = col_reg == last_col_idx_reg;

    // neighbours outside the image read as empty
    assign up_n    = (row_reg == RW'(1)) ? 1'b0 : up_cur;
    assign left_n  = (col_reg == CW'(0)) ? 1'b0 : left_reg;
    assign right_n = last_col ? 1'b0 : mid_nxt;

    always_comb begin
        result = '0;
        emit   = 1'b0;
        if (load_step && row_reg != RW'(0)) begin
            emit               = 1'b1;
            result.is_boundary = mid_cur & ~(up_n & s_data.pixel_filled & left_n & right_n);
            result.row_end     = last_col;
        end else if (flush_step) begin
            // nothing below the last row, so any filled pixel is on the boundary
            emit               = 1'b1;
            result.is_boundary = mid_cur;
            result.row_end     = last_col;
            result.image_end   = last_col;
        end
    end

    // both stores walk together; a write to image_width or image_height reloads the window at column 0
    always_comb begin
        mid_ctrl.step  = load_step || flush_step || (cfg_write && is_known_reg);
        mid_ctrl.wrap  = cfg_write || last_col;
        mid_ctrl.wr_en = load_step;
        up_ctrl        = mid_ctrl;
    end

    bsbm_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .aclk    (aclk),
        .ctrl    (up_ctrl),
        .col     (col_reg),
        .wr_data (mid_cur),
        .cur_bit (up_cur),
        .nxt_bit (up_nxt)
    );

    bsbm_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .aclk    (aclk),
        .ctrl    (mid_ctrl),
        .col     (col_reg),
        .wr_data (s_data.pixel_filled),
        .cur_bit (mid_cur),
        .nxt_bit (mid_nxt)
    );

    bsbm_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data (result),
        .has_room  (queue_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clamp register values to 1..MAX and keep them as last indexes
    always_comb begin
        w_val = cfg_data[IMAGE_WIDTH_W-1:0];
        h_val = cfg_data[IMAGE_HEIGHT_W-1:0];
        last_col_idx_next = last_col_idx_reg;
        last_row_idx_next = last_row_idx_reg;
        if (cfg_index == REG_IMAGE_WIDTH) begin
            if (w_val == '0) begin
                last_col_idx_next = CW'(0);
            end else if (32'(w_val) > MAX_WIDTH) begin
                last_col_idx_next = CW'(MAX_WIDTH - 1);
            end else begin
                last_col_idx_next = CW'(w_val - IMAGE_WIDTH_W'(1));
            end
        end
        if (cfg_index == REG_IMAGE_HEIGHT) begin
            if (h_val == '0) begin
                last_row_idx_next = RW'(0);
            end else if (32'(h_val) > MAX_HEIGHT) begin
                last_row_idx_next = RW'(MAX_HEIGHT - 1);
            end else begin
                last_row_idx_next = RW'(h_val - IMAGE_HEIGHT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg          <= '0;
            row_reg          <= '0;
            flushing_reg     <= 1'b0;
            left_reg         <= 1'b0;
            last_col_idx_reg <= CW'(RST_W - 1);
            last_row_idx_reg <= RW'(RST_H - 1);
        end else if (cfg_write) begin
            if (is_known_reg) begin
                col_reg          <= '0;
                row_reg          <= '0;
                flushing_reg     <= 1'b0;
                left_reg         <= 1'b0;
                last_col_idx_reg <= last_col_idx_next;
                last_row_idx_reg <= last_row_idx_next;
            end
        end else if (load_step) begin
            if (last_col) begin
                col_reg  <= '0;
                left_reg <= 1'b0;
                if (row_reg == last_row_idx_reg) begin
                    flushing_reg <= 1'b1;
                end else begin
                    row_reg <= row_reg + RW'(1);
                end
            end else begin
                col_reg  <= col_reg + CW'(1);
                left_reg <= mid_cur;
            end
        end else if (flush_step) begin
            if (last_col) begin
                col_reg      <= '0;
                row_reg      <= '0;
                flushing_reg <= 1'b0;
                left_reg     <= 1'b0;
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // the upper store's look-ahead bit is only there to feed its own window
    logic unused_up_nxt;
    assign unused_up_nxt = up_nxt;

endmodule

// File: tb/sv/testbench.sv
// testbench: self-checking bench for binary_shape_boundary_marker_core
// depends on bsbm_pkg and the core; random pixel images against a boundary tracker
// that predicts every marked pixel, with bursty input and a stalling result sink
module testbench;
    import bsbm_pkg::*;

    localparam int MAX_W         = 128;
    localparam int MAX_H         = 1024;
    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum int {
        READY_ALWAYS,
        READY_TOGGLE,
        READY_RANDOM,
        READY_SPARSE
    } ready_mode_t;

    // predicts the marked pixels and holds them until the core delivers them
    class boundary_tracker_t;
        bit          upper_row [MAX_W];
        bit          middle_row [MAX_W];
        bit          left_bit;
        int unsigned col_pos;
        int unsigned row_pos;
        bit          flushing;
        int unsigned width_reg;
        int unsigned height_reg;
        out_item_t   expected_marks [$];
        int          mismatches;
        int          results_checked;

        function new();
            foreach (upper_row[i]) upper_row[i] = 1'b0;
            foreach (middle_row[i]) middle_row[i] = 1'b0;
            width_reg       = WIDTH_RESET;
            height_reg      = HEIGHT_RESET;
            mismatches      = 0;
            results_checked = 0;
            restart();
        endfunction

        static function int unsigned clamp_size(int unsigned raw, int unsigned top);
            if (raw < 1) return 1;
            if (raw > top) return top;
            return raw;
        endfunction

        function void restart();
            col_pos  = 0;
            row_pos  = 0;
            flushing = 1'b0;
            left_bit = 1'b0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_IMAGE_WIDTH: begin
                    width_reg = 32'(value[IMAGE_WIDTH_W-1:0]);
                    restart();
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg = 32'(value);
                    restart();
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_marks.size();
        endfunction

        function void note_item(in_item_t item);
            int unsigned w, h, c, r;
            bit          last_col, centre, up, lft, rgt;
            out_item_t   mark;
            w = clamp_size(width_reg, MAX_W);
            h = clamp_size(height_reg, MAX_H);
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = (row_pos >= h) ? h - 1 : row_pos;
            last_col = (c + 1 >= w);
            if (!flushing) begin
                if (item.action) return;
                centre = middle_row[c];
                // row 0 only loads; the row above row 1 is outside the image
                if (r > 0) begin
                    up  = (r == 1) ? 1'b0 : upper_row[c];
                    lft = (c == 0) ? 1'b0 : left_bit;
                    rgt = last_col ? 1'b0 : middle_row[c + 1];
                    mark.is_boundary = centre & ~(up & item.pixel_filled & lft & rgt);
                    mark.row_end     = last_col;
                    mark.image_end   = 1'b0;
                    expected_marks.push_back(mark);
                end
                left_bit      = centre;
                upper_row[c]  = centre;
                middle_row[c] = item.pixel_filled;
                if (last_col) begin
                    col_pos  = 0;
                    left_bit = 1'b0;
                    if (r + 1 >= h) begin
                        row_pos  = r;
                        flushing = 1'b1;
                    end else begin
                        row_pos = r + 1;
                    end
                end else begin
                    col_pos = c + 1;
                    row_pos = r;
                end
                return;
            end
            if (!item.action) return;
            // nothing below the last row, so any filled pixel is on the boundary
            mark.is_boundary = middle_row[c];
            mark.row_end     = last_col;
            mark.image_end   = last_col;
            expected_marks.push_back(mark);
            if (last_col) begin
                restart();
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results_checked++;
            if (expected_marks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: boundary=%0b row_end=%0b image_end=%0b",
                             got.is_boundary, got.row_end, got.image_end);
                return;
            end
            want = expected_marks.pop_front();
            if (got.is_boundary !== want.is_boundary || got.row_end !== want.row_end ||
                got.image_end !== want.image_end) begin
                mismatches++;
                // bits shown as boundary, row_end, image_end
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected %0b%0b%0b, got %0b%0b%0b",
                             results_checked, want.is_boundary, want.row_end,
                             want.image_end, got.is_boundary, got.row_end, got.image_end);
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    boundary_tracker_t tracker;
    int                cycle_count = 0;
    int                burst_left = 0;
    int                image_items = 0;
    int                reg_writes = 0;
    ready_mode_t       ready_mode = READY_ALWAYS;
    int                ready_span = 0;

    binary_shape_boundary_marker_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result sink: stall style is redrawn whenever its random span runs out
    always @(posedge aclk) begin
        if (ready_span == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(3));
            ready_span <= $urandom_range(32, 200);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_TOGGLE: m_ready <= ~m_ready;
            READY_RANDOM: m_ready <= 1'($urandom_range(1));
            default:      m_ready <= ($urandom_range(3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) tracker.check_result(m_data);
            if (s_valid && s_ready) tracker.note_item(s_data);
            if (cfg_valid && cfg_ready) begin
                tracker.write_register(cfg_index, cfg_data);
                reg_writes <= reg_writes + 1;
            end
        end
    end

    task automatic send_item(input logic action, input logic pixel);
        in_item_t item;
        item.action       = action;
        item.pixel_filled = pixel;
        if (burst_left == 0) begin
            if (s_valid) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // sender holds off until every predicted mark has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one image of w x h pixels and its w flushes, optionally cut short
    task automatic send_image(input int w, input int h, input int fill_pct, input int stop_at);
        int total;
        total = w * h + w;
        for (int k = 0; k < total && k != stop_at; k++) begin
            if (k < w * h) begin
                if ($urandom_range(99) < 6) send_item(1'b1, 1'($urandom_range(1)));
                send_item(1'b0, $urandom_range(99) < fill_pct);
            end else begin
                if ($urandom_range(99) < 6) send_item(1'b0, 1'($urandom_range(1)));
                send_item(1'b1, 1'($urandom_range(1)));
            end
            image_items++;
        end
    endtask

    function automatic int pick_fill();
        case ($urandom_range(3))
            0:       return 50;
            1:       return 90;
            2:       return 100;
            default: return 20;
        endcase
    endfunction

    initial begin
        int                    first_random, w_raw, h_raw, w, h, stop_at;
        bit                    restart_needed;
        logic [CFG_DATA_W-1:0] width_word;
        tracker = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset sizes: one full row at width 128 and four of the next, then cut off
        send_image(MAX_W, MAX_H, 50, MAX_W + 4);

        // 3x3 filled square: only the centre is interior
        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_IMAGE_HEIGHT, 11'd3);
        send_item(1'b1, 1'b1);      // flush during loading is dropped
        for (int k = 0; k < 9; k++) begin
            send_item(1'b0, 1'b1);
            if (k == 3) write_reg(REG_UNUSED_2, '1);
        end
        send_item(1'b0, 1'b1);      // pixel during flushing is dropped
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);
        // zero sizes act as a 1x1 image
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_IMAGE_HEIGHT, 11'd0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b1);
        image_items += 18;

        restart_needed = 1'b1;
        w = 1;
        h = 1;
        first_random = image_items;
        while (image_items - first_random < RANDOM_ITEMS) begin
            if (restart_needed || $urandom_range(3) != 0) begin
                w_raw = ($urandom_range(9) == 0) ? 0 :
                        ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                h_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                // upper data bits must not reach the width register
                width_word = {3'($urandom_range(7)), 8'(w_raw)};
                if ($urandom_range(1)) begin
                    write_reg(REG_IMAGE_WIDTH, width_word);
                    write_reg(REG_IMAGE_HEIGHT, 11'(h_raw));
                end else begin
                    write_reg(REG_IMAGE_HEIGHT, 11'(h_raw));
                    write_reg(REG_IMAGE_WIDTH, width_word);
                end
                w = boundary_tracker_t::clamp_size(w_raw, MAX_W);
                h = boundary_tracker_t::clamp_size(h_raw, MAX_H);
                restart_needed = 1'b0;
            end
            if ($urandom_range(11) == 0) write_reg(REG_UNUSED_3, 11'($urandom));
            stop_at = ($urandom_range(7) == 0) ? $urandom_range(0, w * h + w - 1) : -1;
            send_image(w, h, pick_fill(), stop_at);
            if (stop_at >= 0) restart_needed = 1'b1;
            if ($urandom_range(5) == 0) drain_results();
        end

        // width given above the maximum: one full row of 128, then the next row starts
        write_reg(REG_IMAGE_WIDTH, 11'd200);
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        send_image(MAX_W, 2, 50, MAX_W + 4);

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d image items, %0d register writes, images up to 24x6 and 128 wide",
                 image_items, reg_writes);
        $display("checked %0d results, %0d mismatches", tracker.results_checked,
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
